// File: src/kinematic_lerp_motion_driver_core_macros.svh
// assertion macros for the motion driver core
`ifndef KINEMATIC_LERP_MOTION_DRIVER_CORE_MACROS_SVH
`define KINEMATIC_LERP_MOTION_DRIVER_CORE_MACROS_SVH

// plain property, checked on every clock edge outside reset
`define KLMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form, antecedent and consequent given apart
`define KLMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  `KLMD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: src/klmd_pkg.sv
// shared types and codes of the kinematic motion driver
package klmd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  // input item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_MOVE   = 2'd1;
  localparam logic [1:0] KIND_ROTATE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO     = 2'd1;
  localparam logic [1:0] STATUS_DISABLED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_MOVE_MODE   = 2'd1;
  localparam logic [1:0] CFG_ROTATE_MODE = 2'd2;

  // interpolation jobs of one tick
  localparam logic [1:0] JOB_X     = 2'd0;
  localparam logic [1:0] JOB_Y     = 2'd1;
  localparam logic [1:0] JOB_ANGLE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LERP,
    ST_RESP
  } core_state_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_DIFF,
    L_MAG,
    L_MUL,
    L_DIV,
    L_FIN
  } lerp_state_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] from_val;
    logic [WORD_W-1:0] goal_val;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } lerp_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
  } lerp_rsp_t;

endpackage

// File: src/kinematic_lerp_motion_driver_core.sv
// top level of the kinematic motion driver: command decode, channel state, sequencer
// move_to, rotate_to, errors and idle ticks show their result in the cycle after accept
// a tick runs one interpolation per active axis (x, y, angle) in turn on the shared
// multiply and radix-2 divide unit
// one transaction at a time; the next input can be taken the cycle after the result leaves
// reset clears all but the lerp datapath: channels stopped, pose zero, disabled, once mode
`include "kinematic_lerp_motion_driver_core_macros.svh"

module kinematic_lerp_motion_driver_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic               cfg_data_i,
  // input transactions
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_angle_i,
  input  logic signed [31:0] present_x_i,
  input  logic signed [31:0] present_y_i,
  input  logic signed [31:0] present_angle_i,
  input  logic [31:0]        span_i,
  input  logic [31:0]        delta_time_i,
  // result transactions
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic               moving_o,
  output logic               rotating_o,
  output logic [1:0]         status_o
);

  localparam int unsigned W = klmd_pkg::WORD_W;

  klmd_pkg::core_state_e state_q, state_d;

  // configuration registers
  logic enable_q, move_mode_q, rotate_mode_q;

  // translation channel
  logic [W-1:0] move_start_x_q, move_start_y_q, move_goal_x_q, move_goal_y_q;
  logic [W-1:0] move_elapsed_q, move_span_q;
  logic         move_active_q;
  // rotation channel
  logic [W-1:0] rot_start_q, rot_goal_q, rot_elapsed_q, rot_span_q;
  logic         rot_active_q;
  // pose and result status
  logic [W-1:0] pose_x_q, pose_y_q, pose_angle_q;
  logic [1:0]   status_q;

  // sequencer bookkeeping: which axes to interpolate, current axis, job in flight
  logic [2:0] run_q, run_d;
  logic [1:0] job_q;
  logic       issued_q;
  logic       job_needed;
  logic       job_adv;

  logic in_fire, out_fire, cfg_fire;
  logic tick_go;

  // elapsed time advance, formed one bit wider so it never wraps
  logic [W:0] mv_sum, rt_sum;
  logic       mv_end, rt_end;

  klmd_pkg::lerp_req_t lerp_req;
  klmd_pkg::lerp_rsp_t lerp_rsp;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  assign mv_sum = {1'b0, move_elapsed_q} + {1'b0, delta_time_i};
  assign rt_sum = {1'b0, rot_elapsed_q} + {1'b0, delta_time_i};
  assign mv_end = mv_sum >= {1'b0, move_span_q};
  assign rt_end = rt_sum >= {1'b0, rot_span_q};

  // a valid tick on an enabled body refreshes the pose of every active channel
  assign tick_go = (kind_i == klmd_pkg::KIND_TICK) && (delta_time_i != '0) && enable_q;
  assign run_d   = {tick_go && rot_active_q, tick_go && move_active_q, tick_go && move_active_q};

  // walk x, y, angle in turn; axes not flagged pass straight through
  always_comb begin
    unique case (job_q)
      klmd_pkg::JOB_X:     job_needed = run_q[0];
      klmd_pkg::JOB_Y:     job_needed = run_q[1];
      klmd_pkg::JOB_ANGLE: job_needed = run_q[2];
      default:             job_needed = 1'b0;
    endcase
  end
  assign job_adv = !job_needed || lerp_rsp.done;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      klmd_pkg::ST_IDLE: begin
        if (in_fire) state_d = (|run_d) ? klmd_pkg::ST_LERP : klmd_pkg::ST_RESP;
      end
      klmd_pkg::ST_LERP: begin
        if (job_adv && job_q == klmd_pkg::JOB_ANGLE) state_d = klmd_pkg::ST_RESP;
      end
      klmd_pkg::ST_RESP: begin
        if (out_ready_i) state_d = klmd_pkg::ST_IDLE;
      end
      default: state_d = klmd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o     = state_q == klmd_pkg::ST_IDLE;
    out_valid_o    = state_q == klmd_pkg::ST_RESP;
    lerp_req.start = (state_q == klmd_pkg::ST_LERP) && job_needed && !issued_q;
    unique case (job_q)
      klmd_pkg::JOB_X: begin
        lerp_req.from_val = move_start_x_q;
        lerp_req.goal_val = move_goal_x_q;
        lerp_req.num      = move_elapsed_q;
        lerp_req.den      = move_span_q;
      end
      klmd_pkg::JOB_Y: begin
        lerp_req.from_val = move_start_y_q;
        lerp_req.goal_val = move_goal_y_q;
        lerp_req.num      = move_elapsed_q;
        lerp_req.den      = move_span_q;
      end
      default: begin
        lerp_req.from_val = rot_start_q;
        lerp_req.goal_val = rot_goal_q;
        lerp_req.num      = rot_elapsed_q;
        lerp_req.den      = rot_span_q;
      end
    endcase
  end

  klmd_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= klmd_pkg::ST_IDLE;
      enable_q       <= 1'b0;
      move_mode_q    <= 1'b0;
      rotate_mode_q  <= 1'b0;
      move_start_x_q <= '0;
      move_start_y_q <= '0;
      move_goal_x_q  <= '0;
      move_goal_y_q  <= '0;
      move_elapsed_q <= '0;
      move_span_q    <= '0;
      move_active_q  <= 1'b0;
      rot_start_q    <= '0;
      rot_goal_q     <= '0;
      rot_elapsed_q  <= '0;
      rot_span_q     <= '0;
      rot_active_q   <= 1'b0;
      pose_x_q       <= '0;
      pose_y_q       <= '0;
      pose_angle_q   <= '0;
      status_q       <= klmd_pkg::STATUS_OK;
      run_q          <= '0;
      job_q          <= klmd_pkg::JOB_X;
      issued_q       <= 1'b0;
    end else begin
      state_q <= state_d;

      // command decode and channel update at accept
      if (in_fire) begin
        status_q <= klmd_pkg::STATUS_OK;
        run_q    <= run_d;
        job_q    <= klmd_pkg::JOB_X;
        issued_q <= 1'b0;
        unique case (kind_i)
          klmd_pkg::KIND_TICK: begin
            if (delta_time_i == '0) begin
              status_q <= klmd_pkg::STATUS_ZERO;
            end else if (enable_q) begin
              if (move_active_q) begin
                if (mv_end) begin
                  if (move_mode_q) begin
                    // ping-pong: head back from the goal
                    move_start_x_q <= move_goal_x_q;
                    move_goal_x_q  <= move_start_x_q;
                    move_start_y_q <= move_goal_y_q;
                    move_goal_y_q  <= move_start_y_q;
                    move_elapsed_q <= '0;
                  end else begin
                    move_elapsed_q <= move_span_q;
                    move_active_q  <= 1'b0;
                  end
                end else begin
                  move_elapsed_q <= mv_sum[W-1:0];
                end
              end
              if (rot_active_q) begin
                if (rt_end) begin
                  if (rotate_mode_q) begin
                    rot_start_q   <= rot_goal_q;
                    rot_goal_q    <= rot_start_q;
                    rot_elapsed_q <= '0;
                  end else begin
                    rot_elapsed_q <= rot_span_q;
                    rot_active_q  <= 1'b0;
                  end
                end else begin
                  rot_elapsed_q <= rt_sum[W-1:0];
                end
              end
            end
          end
          klmd_pkg::KIND_MOVE: begin
            // zero span outranks the disabled check
            if (span_i == '0) begin
              status_q <= klmd_pkg::STATUS_ZERO;
            end else if (!enable_q) begin
              status_q <= klmd_pkg::STATUS_DISABLED;
            end else begin
              move_active_q  <= 1'b1;
              move_start_x_q <= present_x_i;
              move_start_y_q <= present_y_i;
              move_goal_x_q  <= target_x_i;
              move_goal_y_q  <= target_y_i;
              move_span_q    <= span_i;
              move_elapsed_q <= '0;
              pose_x_q       <= present_x_i;
              pose_y_q       <= present_y_i;
            end
          end
          klmd_pkg::KIND_ROTATE: begin
            if (span_i == '0) begin
              status_q <= klmd_pkg::STATUS_ZERO;
            end else if (!enable_q) begin
              status_q <= klmd_pkg::STATUS_DISABLED;
            end else begin
              rot_active_q  <= 1'b1;
              rot_start_q   <= present_angle_i;
              rot_goal_q    <= target_angle_i;
              rot_span_q    <= span_i;
              rot_elapsed_q <= '0;
              pose_angle_q  <= present_angle_i;
            end
          end
          default: ; // unused kind leaves channels and pose alone
        endcase
      end

      // interpolation sequencing
      if (lerp_req.start) issued_q <= 1'b1;
      if (state_q == klmd_pkg::ST_LERP && job_adv) begin
        issued_q <= 1'b0;
        job_q    <= job_q + 1'b1;
      end
      if (lerp_rsp.done) begin
        unique case (job_q)
          klmd_pkg::JOB_X: pose_x_q     <= lerp_rsp.result;
          klmd_pkg::JOB_Y: pose_y_q     <= lerp_rsp.result;
          default:         pose_angle_q <= lerp_rsp.result;
        endcase
      end

      // configuration writes; dropping enable stops both channels, pose is kept
      if (cfg_fire) begin
        unique case (cfg_index_i)
          klmd_pkg::CFG_ENABLE: begin
            if (enable_q && !cfg_data_i) begin
              move_active_q  <= 1'b0;
              move_elapsed_q <= '0;
              rot_active_q   <= 1'b0;
              rot_elapsed_q  <= '0;
            end
            enable_q <= cfg_data_i;
          end
          klmd_pkg::CFG_MOVE_MODE:   move_mode_q   <= cfg_data_i;
          klmd_pkg::CFG_ROTATE_MODE: rotate_mode_q <= cfg_data_i;
          default: ; // writes past the register list are dropped
        endcase
      end
    end
  end

  // result fields come straight from the architectural state
  assign pos_x_o    = pose_x_q;
  assign pos_y_o    = pose_y_q;
  assign heading_o  = pose_angle_q;
  assign moving_o   = move_active_q;
  assign rotating_o = rot_active_q;
  assign status_o   = status_q;

  // an active channel always holds a usable duration
  `KLMD_ASSERT_IMPL(a_move_span_nonzero, move_active_q, move_span_q != '0,
    "translation active with zero span")
  `KLMD_ASSERT_IMPL(a_rot_span_nonzero, rot_active_q, rot_span_q != '0,
    "rotation active with zero span")
  // the shared unit is only started when idle and only while sequencing
  `KLMD_ASSERT_IMPL(a_lerp_start_ok, lerp_req.start,
    state_q == klmd_pkg::ST_LERP && !lerp_rsp.busy, "interpolation started while busy")
  // a result leaving frees the input side on the next cycle
  `KLMD_ASSERT_IMPL(a_ready_after_out, out_fire, ##1 in_ready_o,
    "input not ready after result transaction")

endmodule

// File: src/klmd_lerp.sv
// shared interpolation unit: from + (goal - from) * num / den, one quotient bit a cycle
module klmd_lerp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  klmd_pkg::lerp_req_t req_i,
  output klmd_pkg::lerp_rsp_t rsp_o
);

  klmd_pkg::lerp_state_e state_q, state_d;

  logic [klmd_pkg::WORD_W-1:0] from_q, goal_q, num_q, den_q;
  logic [klmd_pkg::WORD_W:0]   diff_q;
  logic [klmd_pkg::WORD_W:0]   diff_neg;
  logic                        neg_q;
  logic [klmd_pkg::WORD_W-1:0] mag_q;
  logic [klmd_pkg::WORD_W-1:0] rem_q, lo_q;
  logic [klmd_pkg::CNT_W-1:0]  cnt_q;
  logic [2*klmd_pkg::WORD_W-1:0] prod;
  logic [klmd_pkg::WORD_W:0]   trial;
  logic [klmd_pkg::WORD_W:0]   trial_sub;
  logic                        trial_ge;
  logic                        div_last;

  assign diff_neg  = '0 - diff_q;
  assign prod      = mag_q * num_q;
  assign trial     = {rem_q, lo_q[klmd_pkg::WORD_W-1]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};
  assign div_last  = cnt_q == klmd_pkg::CNT_W'(klmd_pkg::WORD_W - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      klmd_pkg::L_IDLE: if (req_i.start) state_d = klmd_pkg::L_DIFF;
      klmd_pkg::L_DIFF: state_d = klmd_pkg::L_MAG;
      klmd_pkg::L_MAG:  state_d = klmd_pkg::L_MUL;
      klmd_pkg::L_MUL:  state_d = klmd_pkg::L_DIV;
      klmd_pkg::L_DIV:  if (div_last) state_d = klmd_pkg::L_FIN;
      klmd_pkg::L_FIN:  state_d = klmd_pkg::L_IDLE;
      default:          state_d = klmd_pkg::L_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.busy   = state_q != klmd_pkg::L_IDLE;
    rsp_o.done   = state_q == klmd_pkg::L_FIN;
    // quotient never exceeds the magnitude, so a 32-bit add is exact modulo 2^32
    if (den_q == '0) begin
      rsp_o.result = goal_q;
    end else if (neg_q) begin
      rsp_o.result = from_q - lo_q;
    end else begin
      rsp_o.result = from_q + lo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= klmd_pkg::L_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == klmd_pkg::L_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      klmd_pkg::L_IDLE: begin
        if (req_i.start) begin
          from_q <= req_i.from_val;
          goal_q <= req_i.goal_val;
          num_q  <= req_i.num;
          den_q  <= req_i.den;
        end
      end
      klmd_pkg::L_DIFF: begin
        diff_q <= {goal_q[klmd_pkg::WORD_W-1], goal_q} - {from_q[klmd_pkg::WORD_W-1], from_q};
      end
      klmd_pkg::L_MAG: begin
        neg_q <= diff_q[klmd_pkg::WORD_W];
        mag_q <= diff_q[klmd_pkg::WORD_W] ? diff_neg[klmd_pkg::WORD_W-1:0]
                                          : diff_q[klmd_pkg::WORD_W-1:0];
      end
      klmd_pkg::L_MUL: begin
        // upper half stays below den since num never exceeds den
        rem_q <= prod[2*klmd_pkg::WORD_W-1:klmd_pkg::WORD_W];
        lo_q  <= prod[klmd_pkg::WORD_W-1:0];
      end
      klmd_pkg::L_DIV: begin
        rem_q <= trial_ge ? trial_sub[klmd_pkg::WORD_W-1:0] : trial[klmd_pkg::WORD_W-1:0];
        lo_q  <= {lo_q[klmd_pkg::WORD_W-2:0], trial_ge};
      end
      klmd_pkg::L_FIN: ;
      default: ;
    endcase
  end

endmodule

// File: tb/sv/kinematic_lerp_motion_driver_core_tb.sv
// self-checking testbench for the kinematic motion driver core
`timescale 1ns / 100ps

module kinematic_lerp_motion_driver_core_tb;
  import klmd_pkg::*;

  // kind code that the block ignores
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam logic [31:0] S_MIN        = 32'h8000_0000;
  localparam logic [31:0] S_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL1         = 32'hFFFF_FFFF;
  localparam int          IDLE_PCT     = 37;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 191;
  localparam int          DRAIN_CYCLES = 150;

  // one input transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] ta;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pa;
    logic [31:0] span;
    logic [31:0] dt;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic        moving;
    logic        rotating;
    logic [1:0]  status;
  } pose_t;

  // tween channel: the b coordinates are used by translation only
  typedef struct packed {
    logic [31:0] start_a;
    logic [31:0] start_b;
    logic [31:0] goal_a;
    logic [31:0] goal_b;
    logic [31:0] elapsed;
    logic [31:0] span;
    logic        active;
  } chan_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_CMD,
    ROW_TYPED
  } row_e;

  // directed stimulus row: a register write, or a transaction with or without a typed result
  typedef struct packed {
    row_e       what;
    logic [1:0] reg_idx;
    logic       reg_val;
    cmd_t       cmd;
    pose_t      want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic               cfg_data_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i = '0;
  logic signed [31:0] target_x_i = '0;
  logic signed [31:0] target_y_i = '0;
  logic signed [31:0] target_angle_i = '0;
  logic signed [31:0] present_x_i = '0;
  logic signed [31:0] present_y_i = '0;
  logic signed [31:0] present_angle_i = '0;
  logic [31:0]        span_i = '0;
  logic [31:0]        delta_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic signed [31:0] heading_o;
  logic               moving_o;
  logic               rotating_o;
  logic [1:0]         status_o;

  // predictor state, mirrors the block after reset
  logic        en_q = 1'b0;
  logic        mv_pingpong = 1'b0;
  logic        rt_pingpong = 1'b0;
  chan_t       mv_ch = '0;
  chan_t       rt_ch = '0;
  logic [31:0] cur_x = '0;
  logic [31:0] cur_y = '0;
  logic [31:0] cur_angle = '0;

  pose_t expected_poses[$];
  row_t  script[$];
  pose_t seen_pose;
  pose_t due_pose;
  logic  no_idle = 1'b0;
  int    n_mismatch = 0;
  int    n_results = 0;
  int    n_sent = 0;
  int    n_writes = 0;
  int    status_seen[4] = '{0, 0, 0, 0};

  kinematic_lerp_motion_driver_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .target_x_i      (target_x_i),
    .target_y_i      (target_y_i),
    .target_angle_i  (target_angle_i),
    .present_x_i     (present_x_i),
    .present_y_i     (present_y_i),
    .present_angle_i (present_angle_i),
    .span_i          (span_i),
    .delta_time_i    (delta_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .heading_o       (heading_o),
    .moving_o        (moving_o),
    .rotating_o      (rotating_o),
    .status_o        (status_o)
  );

  always #5 clk_i = ~clk_i;

  // start + (goal - start) * num / den, quotient truncated toward zero
  function automatic logic [31:0] tween(logic [31:0] from_v, logic [31:0] goal_v,
                                        logic [31:0] num, logic [31:0] den);
    logic signed [63:0] s;
    logic signed [63:0] d;
    logic signed [63:0] r;
    logic [63:0]        mag;
    logic [63:0]        q;
    if (den == '0) begin
      return goal_v;
    end
    s   = {{32{from_v[31]}}, from_v};
    d   = {{32{goal_v[31]}}, goal_v} - s;
    mag = d[63] ? -d : d;
    // magnitude and num are both below 2**32, so the product fits in 64 bits
    q   = (mag * {32'b0, num}) / {32'b0, den};
    r   = d[63] ? s - $signed(q) : s + $signed(q);
    return r[31:0];
  endfunction

  // add a time step to an active channel, clamp at span, then bounce or stop
  function automatic chan_t step_chan(chan_t c, logic [31:0] dt, logic pingpong);
    logic [32:0] sum;
    logic [31:0] t;
    sum = {1'b0, c.elapsed} + {1'b0, dt};
    if (sum >= {1'b0, c.span}) begin
      if (pingpong) begin
        t = c.start_a; c.start_a = c.goal_a; c.goal_a = t;
        t = c.start_b; c.start_b = c.goal_b; c.goal_b = t;
        c.elapsed = '0;
      end else begin
        c.elapsed = c.span;
        c.active  = 1'b0;
      end
    end else begin
      c.elapsed = sum[31:0];
    end
    return c;
  endfunction

  // expected result of one transaction, updates the predictor state
  function automatic pose_t apply_cmd(cmd_t c);
    pose_t r;
    r.status = STATUS_OK;
    case (c.kind)
      KIND_TICK: begin
        // zero step is flagged even while disabled, a disabled tick does nothing
        if (c.dt == '0) begin
          r.status = STATUS_ZERO;
        end else if (en_q) begin
          if (mv_ch.active) begin
            mv_ch = step_chan(mv_ch, c.dt, mv_pingpong);
            cur_x = tween(mv_ch.start_a, mv_ch.goal_a, mv_ch.elapsed, mv_ch.span);
            cur_y = tween(mv_ch.start_b, mv_ch.goal_b, mv_ch.elapsed, mv_ch.span);
          end
          if (rt_ch.active) begin
            rt_ch     = step_chan(rt_ch, c.dt, rt_pingpong);
            cur_angle = tween(rt_ch.start_a, rt_ch.goal_a, rt_ch.elapsed, rt_ch.span);
          end
        end
      end
      KIND_MOVE, KIND_ROTATE: begin
        if (c.span == '0) begin
          r.status = STATUS_ZERO;
        end else if (!en_q) begin
          r.status = STATUS_DISABLED;
        end else if (c.kind == KIND_MOVE) begin
          mv_ch.active  = 1'b1;
          mv_ch.start_a = c.px;
          mv_ch.start_b = c.py;
          mv_ch.goal_a  = c.tx;
          mv_ch.goal_b  = c.ty;
          mv_ch.span    = c.span;
          mv_ch.elapsed = '0;
          cur_x         = c.px;
          cur_y         = c.py;
        end else begin
          rt_ch.active  = 1'b1;
          rt_ch.start_a = c.pa;
          rt_ch.goal_a  = c.ta;
          rt_ch.span    = c.span;
          rt_ch.elapsed = '0;
          cur_angle     = c.pa;
        end
      end
      default: ;
    endcase
    r.pos_x    = cur_x;
    r.pos_y    = cur_y;
    r.heading  = cur_angle;
    r.moving   = mv_ch.active;
    r.rotating = rt_ch.active;
    return r;
  endfunction

  function automatic void set_reg(logic [1:0] idx, logic val);
    case (idx)
      CFG_ENABLE: begin
        // falling enable stops both channels, pose and modes are kept
        if (en_q && !val) begin
          mv_ch.active  = 1'b0;
          mv_ch.elapsed = '0;
          rt_ch.active  = 1'b0;
          rt_ch.elapsed = '0;
        end
        en_q = val;
      end
      CFG_MOVE_MODE:   mv_pingpong = val;
      CFG_ROTATE_MODE: rt_pingpong = val;
      default: ;
    endcase
  endfunction

  function automatic cmd_t mk_cmd(logic [1:0] kind, logic [31:0] tx, logic [31:0] ty,
                                  logic [31:0] ta, logic [31:0] px, logic [31:0] py,
                                  logic [31:0] pa, logic [31:0] span, logic [31:0] dt);
    cmd_t c;
    c.kind = kind; c.tx = tx; c.ty = ty; c.ta = ta;
    c.px = px; c.py = py; c.pa = pa; c.span = span; c.dt = dt;
    return c;
  endfunction

  function automatic cmd_t tick_cmd(logic [31:0] dt);
    return mk_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, dt);
  endfunction

  function automatic pose_t mk_pose(logic [31:0] x, logic [31:0] y, logic [31:0] a,
                                    logic mv, logic rt, logic [1:0] st);
    pose_t p;
    p.pos_x = x; p.pos_y = y; p.heading = a;
    p.moving = mv; p.rotating = rt; p.status = st;
    return p;
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic val);
    row_t r;
    r = '0;
    r.what = ROW_REG; r.reg_idx = idx; r.reg_val = val;
    script.push_back(r);
  endfunction

  function automatic void add_cmd(cmd_t c);
    row_t r;
    r = '0;
    r.what = ROW_CMD; r.cmd = c;
    script.push_back(r);
  endfunction

  function automatic void add_typed(cmd_t c, pose_t p);
    row_t r;
    r = '0;
    r.what = ROW_TYPED; r.cmd = c; r.want = p;
    script.push_back(r);
  endfunction

  // mostly ticks after commands, with small spans and steps so channels reach their ends
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 62)      c.kind = KIND_TICK;
    else if (pick < 78) c.kind = KIND_MOVE;
    else if (pick < 94) c.kind = KIND_ROTATE;
    else                c.kind = KIND_UNUSED;
    c.tx = $urandom; c.ty = $urandom; c.ta = $urandom;
    c.px = $urandom; c.py = $urandom; c.pa = $urandom;
    pick = $urandom_range(99);
    if (pick < 5)       c.span = '0;
    else if (pick < 50) c.span = $urandom_range(1, 16);
    else if (pick < 80) c.span = $urandom_range(1, 1 << 20);
    else                c.span = $urandom;
    pick = $urandom_range(99);
    if (pick < 4)       c.dt = '0;
    else if (pick < 55) c.dt = $urandom_range(1, 8);
    else if (pick < 80) c.dt = $urandom_range(1, 1 << 18);
    else if (pick < 95) c.dt = $urandom;
    else                c.dt = ALL1;
    return c;
  endfunction

  // present one transaction after a random gap, expectation recorded at the accept edge
  task automatic send_cmd(input cmd_t c, input logic typed, input pose_t want);
    int    gap;
    pose_t pred;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    cfg_valid_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= c.kind;
    target_x_i      <= c.tx;
    target_y_i      <= c.ty;
    target_angle_i  <= c.ta;
    present_x_i     <= c.px;
    present_y_i     <= c.py;
    present_angle_i <= c.pa;
    span_i          <= c.span;
    delta_time_i    <= c.dt;
    do @(posedge clk_i); while (!in_ready_o);
    // valid stays high here so a back-to-back transaction needs no second assignment
    pred = apply_cmd(c);
    expected_poses.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_reg(idx, val);
    n_writes++;
  endtask

  // block is idle once every expected result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
  endtask

  // result side stalls at random except in the no-idle stretch
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_pose = mk_pose(pos_x_o, pos_y_o, heading_o, moving_o, rotating_o, status_o);
      n_results++;
      status_seen[seen_pose.status]++;
      if (expected_poses.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("result with no transaction pending: x=%h y=%h a=%h mv=%b rt=%b st=%0d",
                   seen_pose.pos_x, seen_pose.pos_y, seen_pose.heading,
                   seen_pose.moving, seen_pose.rotating, seen_pose.status);
        end
      end else begin
        due_pose = expected_poses.pop_front();
        if (seen_pose.pos_x !== due_pose.pos_x || seen_pose.pos_y !== due_pose.pos_y ||
            seen_pose.heading !== due_pose.heading || seen_pose.moving !== due_pose.moving ||
            seen_pose.rotating !== due_pose.rotating || seen_pose.status !== due_pose.status)
        begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch on result %0d: expected x=%h y=%h a=%h mv=%b rt=%b st=%0d",
                     n_results, due_pose.pos_x, due_pose.pos_y, due_pose.heading,
                     due_pose.moving, due_pose.rotating, due_pose.status);
            $display("                      actual   x=%h y=%h a=%h mv=%b rt=%b st=%0d",
                     seen_pose.pos_x, seen_pose.pos_y, seen_pose.heading,
                     seen_pose.moving, seen_pose.rotating, seen_pose.status);
          end
        end
      end
    end
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    // disabled after reset: ticks do nothing, commands are refused, zero check comes first
    add_typed(tick_cmd(1), mk_pose(0, 0, 0, 0, 0, STATUS_OK));
    add_typed(mk_cmd(KIND_MOVE, 7, 8, 0, 3, 4, 0, 5, 0),
              mk_pose(0, 0, 0, 0, 0, STATUS_DISABLED));
    add_typed(mk_cmd(KIND_ROTATE, 0, 0, 9, 0, 0, 2, 0, 0),
              mk_pose(0, 0, 0, 0, 0, STATUS_ZERO));
    add_typed(tick_cmd(0), mk_pose(0, 0, 0, 0, 0, STATUS_ZERO));
    add_typed(mk_cmd(KIND_UNUSED, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1),
              mk_pose(0, 0, 0, 0, 0, STATUS_OK));
    add_reg(CFG_ENABLE, 1'b1);
    // full-range move and rotation, then one huge step finishes both exactly on the goal
    add_typed(mk_cmd(KIND_MOVE, S_MAX, S_MIN, 0, S_MIN, S_MAX, 0, ALL1, 0),
              mk_pose(S_MIN, S_MAX, 0, 1, 0, STATUS_OK));
    add_typed(mk_cmd(KIND_ROTATE, 0, 0, S_MAX, 0, 0, S_MIN, 1, 0),
              mk_pose(S_MIN, S_MAX, S_MIN, 1, 1, STATUS_OK));
    add_typed(tick_cmd(ALL1), mk_pose(S_MAX, S_MIN, S_MAX, 0, 0, STATUS_OK));
    // truncation of a negative delta, then an elapsed sum that would wrap 32 bits
    add_cmd(mk_cmd(KIND_MOVE, 10, -10, 0, 0, 0, 0, 3, 0));
    add_cmd(tick_cmd(1));
    add_cmd(tick_cmd(ALL1));
    add_cmd(mk_cmd(KIND_ROTATE, 0, 0, 5, 0, 0, 6, 0, 0));
    // ping-pong on both channels, crossing the end and coming back
    add_reg(CFG_MOVE_MODE, 1'b1);
    add_reg(CFG_ROTATE_MODE, 1'b1);
    add_cmd(mk_cmd(KIND_MOVE, 100, -50, 0, -100, 50, 0, 4, 0));
    add_cmd(mk_cmd(KIND_ROTATE, 0, 0, S_MAX, 0, 0, S_MIN, 2, 0));
    add_cmd(tick_cmd(1));
    add_cmd(tick_cmd(3));
    add_cmd(tick_cmd(2));
    // disabling mid-motion stops both channels but keeps the pose
    add_reg(CFG_ENABLE, 1'b0);
    add_cmd(tick_cmd(5));
    add_cmd(mk_cmd(KIND_ROTATE, 0, 0, 3, 0, 0, 1, 7, 0));
    add_reg(CFG_ENABLE, 1'b1);
    add_reg(CFG_MOVE_MODE, 1'b0);
    add_reg(CFG_ROTATE_MODE, 1'b0);
    add_cmd(tick_cmd(1));
    add_cmd(mk_cmd(KIND_ROTATE, 0, 0, S_MAX, 0, 0, ALL1, 32'h8000_0000, 0));
    add_cmd(tick_cmd(32'h4000_0000));
    add_cmd(mk_cmd(KIND_UNUSED, 1, 2, 3, 4, 5, 6, 7, 8));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      case (script[i].what)
        ROW_REG: begin
          drain();
          write_reg(script[i].reg_idx, script[i].reg_val);
        end
        ROW_CMD:   send_cmd(script[i].cmd, 1'b0, '0);
        ROW_TYPED: send_cmd(script[i].cmd, 1'b1, script[i].want);
        default: ;
      endcase
    end

    // random phases walk every mode pair, two of them disabled after running enabled
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(CFG_ENABLE, (ph != 3) && (ph != 6));
      write_reg(CFG_MOVE_MODE, ph[0]);
      write_reg(CFG_ROTATE_MODE, ph[1]);
      // one whole phase runs with no gaps on either side
      no_idle = (ph == 4);
      repeat (PHASE_ITEMS) send_cmd(rand_cmd(), 1'b0, '0);
    end
    no_idle = 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d transactions and %0d register writes, checked %0d results",
             n_sent, n_writes, n_results);
    $display("result status mix: %0d ok, %0d zero time, %0d refused while disabled",
             status_seen[STATUS_OK], status_seen[STATUS_ZERO], status_seen[STATUS_DISABLED]);
    if (n_mismatch == 0 && expected_poses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: kinematic_lerp_motion_driver_core.f
+incdir+src
src/klmd_pkg.sv
src/klmd_lerp.sv
src/kinematic_lerp_motion_driver_core.sv
tb/sv/kinematic_lerp_motion_driver_core_tb.sv
